>>> rtl/ora_pkg.sv
package ora_pkg;

   // Field and datapath widths
   localparam int COORD_W     = 22;
   localparam int SPAN_W      = COORD_W + 1;  // |diff| + 1 reaches 2^22
   localparam int RATIO_W     = 9;            // ratio 0..256
   localparam int RATIO_SHIFT = 8;
   localparam int HEADING_W   = 13;

   // Octant flag bits: x swapped, y swapped, major span on y
   localparam int FLAG_W = 3;
   localparam logic [FLAG_W-1:0] OCT_PLAIN  = 3'b000;
   localparam logic [FLAG_W-1:0] OCT_X      = 3'b001;
   localparam logic [FLAG_W-1:0] OCT_Y      = 3'b010;
   localparam logic [FLAG_W-1:0] OCT_XY     = 3'b011;
   localparam logic [FLAG_W-1:0] OCT_MAJ    = 3'b100;
   localparam logic [FLAG_W-1:0] OCT_MAJ_X  = 3'b101;
   localparam logic [FLAG_W-1:0] OCT_MAJ_Y  = 3'b110;
   localparam logic [FLAG_W-1:0] OCT_MAJ_XY = 3'b111;

   // One divider stage: running remainder and partial quotient
   typedef struct packed {
      logic [FLAG_W-1:0]  flags;
      logic [SPAN_W-1:0]  major;
      logic [SPAN_W-1:0]  rem;
      logic [RATIO_W-1:0] quot;
   } div_type;

   // Restoring division, one quotient bit
   function automatic div_type div_step(div_type s);
      div_type         r;
      logic [SPAN_W:0] dbl;
      r   = s;
      dbl = {s.rem, 1'b0};
      if (dbl >= {1'b0, s.major}) begin
         r.rem  = SPAN_W'(dbl - {1'b0, s.major});
         r.quot = {s.quot[RATIO_W-2:0], 1'b1};
      end else begin
         r.rem  = dbl[SPAN_W-1:0];
         r.quot = {s.quot[RATIO_W-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

>>> rtl/octant_ratio_angle_2d.sv
// Approximate heading from a start point to a target point (linear octant atan2).
// Request channel: req_valid/req_ready with req_from_x, req_from_y, req_to_x,
// req_to_y (22-bit signed). Response channel: rsp_valid/rsp_ready with
// rsp_heading (13 bits), where FULL_TURN units make one turn; the value may
// equal FULL_TURN itself.
// From request to response, one stage forms the spans, one picks major/minor
// and the top ratio bit, eight stages run the restoring divider one quotient
// bit each, one stage scales the ratio by an eighth turn and the last registers
// the octant-mapped heading. Throughput is one request per cycle while the
// receiver keeps taking responses; the divider stages set the depth.
// Every stage carries a valid bit; a stage takes new data whenever it is empty
// or the stage after it moves, so a stalled receiver holds the response and
// bubbles in the pipe still fill. req_ready only drops once all 12 stages hold
// a request. Synchronous reset empties the pipeline; no response is pending.
module octant_ratio_angle_2d
   import ora_pkg::*;
#(
   parameter int FULL_TURN = 4096
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [COORD_W-1:0]   req_from_x,
   input  logic signed [COORD_W-1:0]   req_from_y,
   input  logic signed [COORD_W-1:0]   req_to_x,
   input  logic signed [COORD_W-1:0]   req_to_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [HEADING_W-1:0]        rsp_heading
);

   localparam int QUARTER  = FULL_TURN / 4;
   localparam int EIGHTH   = QUARTER / 2;
   localparam int EIGHTH_W = $clog2(EIGHTH + 1);
   localparam int PROD_W   = RATIO_W + EIGHTH_W;
   localparam int A_W      = PROD_W - RATIO_SHIFT;
   localparam int TURN_W   = $clog2(FULL_TURN + 1);

   localparam int DIV_STEPS = RATIO_W - 1;
   localparam int ST_SPAN   = 0;
   localparam int ST_DIV0   = 1;
   localparam int ST_MUL    = ST_DIV0 + DIV_STEPS + 1;
   localparam int ST_OUT    = ST_MUL + 1;
   localparam int NSTG      = ST_OUT + 1;

   // Stage valid bits and ready chain
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_src;
   logic [NSTG:0]   rdy;

   assign vld_src = {vld_ff[NSTG-2:0], req_valid};

   // Ready ripples back from the output stage
   always_comb begin
      rdy[NSTG] = rsp_ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_src[k];
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[ST_OUT];

   // Spans (|diff| + 1) and swap flags
   logic              xswap_in, yswap_in;
   logic [SPAN_W-1:0] sx_in, sy_in;
   logic              xswap_ff, yswap_ff;
   logic [SPAN_W-1:0] sx_ff, sy_ff;

   always_comb begin
      xswap_in = req_from_x > req_to_x;
      yswap_in = req_from_y > req_to_y;
      sx_in = xswap_in ? SPAN_W'(SPAN_W'(req_from_x) - SPAN_W'(req_to_x) + SPAN_W'(1))
                       : SPAN_W'(SPAN_W'(req_to_x) - SPAN_W'(req_from_x) + SPAN_W'(1));
      sy_in = yswap_in ? SPAN_W'(SPAN_W'(req_from_y) - SPAN_W'(req_to_y) + SPAN_W'(1))
                       : SPAN_W'(SPAN_W'(req_to_y) - SPAN_W'(req_from_y) + SPAN_W'(1));
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_SPAN] && vld_src[ST_SPAN]) begin
         xswap_ff <= xswap_in;
         yswap_ff <= yswap_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
      end
   end

   // Major/minor pick and the top ratio bit (set only when spans are equal)
   div_type div_in;
   div_type div_ff [DIV_STEPS+1];

   always_comb begin
      logic              ymaj;
      logic [SPAN_W-1:0] minor;
      logic              top;
      ymaj         = sy_ff > sx_ff;
      div_in.flags = {ymaj, yswap_ff, xswap_ff};
      div_in.major = ymaj ? sy_ff : sx_ff;
      minor        = ymaj ? sx_ff : sy_ff;
      top          = minor == div_in.major;
      div_in.rem   = top ? '0 : minor;
      div_in.quot  = {{(RATIO_W-1){1'b0}}, top};
   end

   // Divider pipeline, one quotient bit per stage
   always_ff @(posedge clock) begin
      if (rdy[ST_DIV0] && vld_src[ST_DIV0]) div_ff[0] <= div_in;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         if (rdy[ST_DIV0+j] && vld_src[ST_DIV0+j]) div_ff[j] <= div_step(div_ff[j-1]);
      end
   end

   // Scale ratio to an eighth turn
   logic [PROD_W-1:0] prod;
   logic [A_W-1:0]    ang_ff;
   logic [FLAG_W-1:0] flags_ff;

   assign prod = PROD_W'(div_ff[DIV_STEPS].quot) * PROD_W'(EIGHTH);

   always_ff @(posedge clock) begin
      if (rdy[ST_MUL] && vld_src[ST_MUL]) begin
         ang_ff   <= prod[PROD_W-1:RATIO_SHIFT];
         flags_ff <= div_ff[DIV_STEPS].flags;
      end
   end

   // Octant map
   logic [TURN_W-1:0]    a;
   logic [TURN_W-1:0]    h;
   logic [HEADING_W-1:0] heading_ff;

   always_comb begin
      a = TURN_W'(ang_ff);
      case (flags_ff)
         OCT_PLAIN: h = TURN_W'(QUARTER) - a;
         OCT_X:     h = TURN_W'(3 * QUARTER) + a;
         OCT_Y:     h = TURN_W'(QUARTER) + a;
         OCT_XY:    h = TURN_W'(3 * QUARTER) - a;
         OCT_MAJ:   h = a;
         OCT_MAJ_X: h = TURN_W'(FULL_TURN) - a;
         OCT_MAJ_Y: h = TURN_W'(2 * QUARTER) - a;
         default:   h = TURN_W'(2 * QUARTER) + a;  // all three flags
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[ST_OUT] && vld_src[ST_OUT]) heading_ff <= HEADING_W'(h);
   end

   assign rsp_heading = heading_ff;

endmodule

>>> rtl/ora_checker.sv
module ora_checker
   import ora_pkg::*;
#(
   parameter int FULL_TURN = 4096
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [HEADING_W-1:0] rsp_heading
);

   // Reset leaves nothing to deliver
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // An empty or draining output stage means the whole pipe can take a request
   a_no_lockup: assert property (@(posedge clock)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused while output stage free");

   // Heading stays within one turn when the turn fits the field
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (FULL_TURN >= (1 << HEADING_W)) || (rsp_heading <= FULL_TURN))
      else $error("heading beyond a full turn");

   // Stalled response holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_heading))
      else $error("stalled response changed");

endmodule

bind octant_ratio_angle_2d ora_checker #(.FULL_TURN(FULL_TURN)) u_ora_checker (.*);

>>> verif/octant_ratio_angle_2d_test.sv
`timescale 1ns / 100ps

module octant_ratio_angle_2d_test;
   import ora_pkg::*;

   localparam int FULL_TURN = 4096;
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam int RANDOM_PER_PHASE = 234;
   localparam int SETTLE_CYCLES    = 40;

   // Expected headings, oldest first, with a predictor of the octant map
   class heading_scoreboard;
      int                   full_turn;
      int                   errors;
      logic [HEADING_W-1:0] due_headings[$];

      function new(int turn);
         full_turn = turn;
         errors    = 0;
      endfunction

      function logic [HEADING_W-1:0] predict_heading(logic signed [COORD_W-1:0] fx,
                                                     logic signed [COORD_W-1:0] fy,
                                                     logic signed [COORD_W-1:0] tx,
                                                     logic signed [COORD_W-1:0] ty);
         longint            ax, ay, bx, by;
         longint            span_x, span_y, major, minor, ratio, angle;
         longint            quarter, eighth, h;
         logic [FLAG_W-1:0] oct;
         ax      = longint'(fx);
         ay      = longint'(fy);
         bx      = longint'(tx);
         by      = longint'(ty);
         quarter = full_turn / 4;
         eighth  = quarter / 2;
         oct     = OCT_PLAIN;
         // spans are |difference| + 1, so never zero
         if (ax > bx) begin
            oct    = oct | OCT_X;
            span_x = ax - bx + 1;
         end else begin
            span_x = bx - ax + 1;
         end
         if (ay > by) begin
            oct    = oct | OCT_Y;
            span_y = ay - by + 1;
         end else begin
            span_y = by - ay + 1;
         end
         if (span_y > span_x) begin
            oct   = oct | OCT_MAJ;
            major = span_y;
            minor = span_x;
         end else begin
            major = span_x;
            minor = span_y;
         end
         ratio = (minor << RATIO_SHIFT) / major;
         angle = (ratio * eighth) >> RATIO_SHIFT;
         case (oct)
            OCT_PLAIN:  h = quarter - angle;
            OCT_X:      h = quarter * 3 + angle;
            OCT_Y:      h = quarter + angle;
            OCT_XY:     h = quarter * 3 - angle;
            OCT_MAJ:    h = angle;
            OCT_MAJ_X:  h = full_turn - angle;
            OCT_MAJ_Y:  h = quarter * 2 - angle;
            default:    h = quarter * 2 + angle;
         endcase
         // a full turn stays as it is; only the port width truncates
         return HEADING_W'(h);
      endfunction

      function void note_request(logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
                                 logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty);
         due_headings.push_back(predict_heading(fx, fy, tx, ty));
      endfunction

      function void check_heading(logic [HEADING_W-1:0] actual);
         logic [HEADING_W-1:0] due;
         if (due_headings.size() == 0) begin
            $error("heading: no response expected, actual %0d", actual);
            errors++;
         end else begin
            due = due_headings.pop_front();
            if (actual !== due) begin
               $error("heading: expected %0d, actual %0d", due, actual);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return due_headings.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COORD_W-1:0] req_from_x;
   logic signed [COORD_W-1:0] req_from_y;
   logic signed [COORD_W-1:0] req_to_x;
   logic signed [COORD_W-1:0] req_to_y;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [HEADING_W-1:0]      rsp_heading;

   int                send_idle_pct;
   int                recv_idle_pct;
   heading_scoreboard board;

   octant_ratio_angle_2d #(.FULL_TURN(FULL_TURN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_from_x  (req_from_x),
      .req_from_y  (req_from_y),
      .req_to_x    (req_to_x),
      .req_to_y    (req_to_y),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_heading (rsp_heading)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Watch both handshakes
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_request(req_from_x, req_from_y, req_to_x, req_to_y);
         if (rsp_valid && rsp_ready)
            board.check_heading(rsp_heading);
      end
   end

   // One request; valid only drops when the sender chooses to idle
   task automatic send_request(logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
                               logic signed [COORD_W-1:0] tx, logic signed [COORD_W-1:0] ty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_from_x <= fx;
      req_from_y <= fy;
      req_to_x   <= tx;
      req_to_y   <= ty;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] edge_coord();
      case ($urandom_range(4))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Random point pairs: wide, close together, at the extremes, near axes and diagonals
   task automatic send_random();
      logic signed [COORD_W-1:0] fx, fy, tx, ty;
      int                        dx, dy, d;
      fx = COORD_W'($urandom);
      fy = COORD_W'($urandom);
      tx = COORD_W'($urandom);
      ty = COORD_W'($urandom);
      case ($urandom_range(3))
         0: ;
         1: begin
            dx = $urandom_range(600) - 300;
            dy = $urandom_range(600) - 300;
            tx = fx + COORD_W'(dx);
            ty = fy + COORD_W'(dy);
         end
         2: begin
            fx = edge_coord();
            fy = edge_coord();
            tx = edge_coord();
            ty = edge_coord();
         end
         default: begin
            d  = $urandom_range(1, 2000);
            dx = $urandom_range(1) ? d : -d;
            case ($urandom_range(3))
               0:       dy = 0;
               1:       dy = d;
               2:       dy = -d;
               default: dy = d + $urandom_range(2) - 1;
            endcase
            if ($urandom_range(1)) begin
               tx = fx + COORD_W'(dx);
               ty = fy + COORD_W'(dy);
            end else begin
               tx = fx + COORD_W'(dy);
               ty = fy + COORD_W'(dx);
            end
         end
      endcase
      send_request(fx, fy, tx, ty);
   endtask

   initial begin
      board         = new(FULL_TURN);
      send_idle_pct = 22;
      recv_idle_pct = 47;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_from_x <= '0;
      req_from_y <= '0;
      req_to_x   <= '0;
      req_to_y   <= '0;
      rsp_ready  <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // equal points, at zero and at both extremes
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(0), COORD_W'(0));
      send_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
      send_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
      // widest spans
      send_request(COORD_MIN, COORD_W'(0), COORD_MAX, COORD_W'(0));
      send_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
      send_request(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
      send_request(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      send_request(COORD_W'(0), COORD_MAX, COORD_W'(0), COORD_MIN);
      // one request per octant
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(10), COORD_W'(3));
      send_request(COORD_W'(10), COORD_W'(0), COORD_W'(0), COORD_W'(3));
      send_request(COORD_W'(0), COORD_W'(3), COORD_W'(10), COORD_W'(0));
      send_request(COORD_W'(10), COORD_W'(3), COORD_W'(0), COORD_W'(0));
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(3), COORD_W'(10));
      send_request(COORD_W'(3), COORD_W'(0), COORD_W'(0), COORD_W'(10));
      send_request(COORD_W'(0), COORD_W'(10), COORD_W'(3), COORD_W'(0));
      send_request(COORD_W'(3), COORD_W'(10), COORD_W'(0), COORD_W'(0));
      // heading of exactly a full turn
      send_request(COORD_W'(1), COORD_W'(0), COORD_W'(0), COORD_W'(1000));
      // diagonal tie, zero x difference, zero ratio
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(5), COORD_W'(5));
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(0), COORD_W'(7));
      send_request(COORD_W'(0), COORD_W'(0), COORD_W'(1000), COORD_W'(0));

      repeat (RANDOM_PER_PHASE) send_random();

      // sender holds off until the pipe has drained
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);

      send_idle_pct = 47;
      recv_idle_pct = 22;
      repeat (RANDOM_PER_PHASE) send_random();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) send_random();
      req_valid <= 1'b0;
      @(posedge clock);

      // drain, then let the pipe settle
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (board.outstanding() != 0) begin
         $error("heading: %0d responses never arrived", board.outstanding());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("octant_ratio_angle_2d: match");
      end else begin
         $display("octant_ratio_angle_2d: mismatch");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("octant_ratio_angle_2d: mismatch");
      $finish;
   end

endmodule
